@@ rtl/cfq_pkg.sv @@
`default_nettype none

package cfq_pkg;

  localparam int CFQ_DEPTH   = 16;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int VAL_W       = 31;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 3;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_DUMP = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_POPPED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_DUMP   = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    push;        // write at tail, advance tail, count up
    logic    start_rd;    // load read pointer from head
    logic    rd_all;      // with start_rd: walk all entries (capped), else one
    logic    rd_en;       // issue storage read at read pointer
    logic    ld_ram;      // load result from read data, step read pointer
    status_e ram_status;
    logic    pop_adv;     // advance head, count down
    logic    ld_imm;      // load a result without data
    status_e imm_status;
  } cfq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic remain_one;
    logic out_free;
  } cfq_stat_t;

endpackage

`default_nettype wire

@@ rtl/cfq_ram.sv @@
`default_nettype none

module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/cfq_ctrl.sv @@
`default_nettype none

module cfq_ctrl import cfq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [CMD_W-1:0] req_cmd_i,
  output logic                  req_ready_o,
  input  wire cfq_stat_t        stat_i,
  output cfq_cmd_t              cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       dump_q, dump_d;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    dump_d  = dump_q;
    cmd_o   = '{default: '0, ram_status: ST_POPPED, imm_status: ST_EMPTY};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(req_cmd_i))
            CMD_PUSH: begin
              cmd_o.ld_imm = 1'b1;
              if (stat_i.full) begin
                cmd_o.imm_status = ST_FULL;
              end else begin
                cmd_o.imm_status = ST_PUSHED;
                cmd_o.push       = 1'b1;
              end
            end
            CMD_POP, CMD_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.ld_imm     = 1'b1;
                cmd_o.imm_status = ST_EMPTY;
              end else begin
                cmd_o.start_rd = 1'b1;
                cmd_o.rd_all   = (cmd_e'(req_cmd_i) == CMD_DUMP);
                dump_d         = (cmd_e'(req_cmd_i) == CMD_DUMP);
                state_d        = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.ld_ram     = 1'b1;
          cmd_o.ram_status = dump_q ? ST_DUMP : ST_POPPED;
          cmd_o.pop_adv    = !dump_q;
          state_d          = stat_i.remain_one ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dump_q  <= dump_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cfq_dp.sv @@
`default_nettype none

module cfq_dp import cfq_pkg::*; #(
  parameter int DEPTH = CFQ_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic [VAL_W-1:0]  item_value_i,
  input  wire cfq_cmd_t          cmd_i,
  output cfq_stat_t              stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [STAT_W-1:0]      out_status_o,
  output logic [VAL_W-1:0]       out_value_o,
  output logic                   out_last_o
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int M1     = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
  localparam int M2     = (M1 > CAP_W) ? M1 : CAP_W;
  localparam int CMP_W  = (M2 > RES_W) ? M2 : RES_W;
  localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     tail_q, tail_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [RES_W-1:0]  remain_q, remain_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic [VAL_W-1:0]  rd_data;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                               input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] n;
    n = CMP_W'(idx) + CMP_W'(1);
    if (n >= CMP_W'(cap)) begin
      return '0;
    end
    return n[IW-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    if (v == '0) begin
      return CAP_W'(1);
    end
    if (CMP_W'(v) > CMP_W'(DEPTH)) begin
      return CAP_W'(DEPTH);
    end
    return v;
  endfunction

  cfq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(tail_q),
    .wdata_i(item_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(rd_data)
  );

  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.full       = (CMP_W'(fill_q) >= CMP_W'(cap_q));
  assign stat_o.remain_one = (remain_q == RES_W'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    cap_d    = cap_q;
    rd_idx_d = rd_idx_q;
    remain_d = remain_q;
    if (cfg_we_i) begin
      cap_d  = clamp_cap(cfg_wdata_i);
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
    end else begin
      if (cmd_i.push) begin
        tail_d = ring_next(tail_q, cap_q);
        fill_d = fill_q + CNT_W'(1);
      end
      if (cmd_i.pop_adv) begin
        head_d = ring_next(head_q, cap_q);
        fill_d = fill_q - CNT_W'(1);
      end
      if (cmd_i.start_rd) begin
        rd_idx_d = head_q;
        if (!cmd_i.rd_all) begin
          remain_d = RES_W'(1);
        end else if (CMP_W'(fill_q) > CMP_W'(MAX_RESULTS)) begin
          remain_d = RES_W'(MAX_RESULTS);
        end else begin
          remain_d = RES_W'(fill_q);
        end
      end
      if (cmd_i.ld_ram) begin
        rd_idx_d = ring_next(rd_idx_q, cap_q);
        remain_d = remain_q - RES_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    if (cmd_i.ld_imm) begin
      out_valid_d  = 1'b1;
      out_status_d = cmd_i.imm_status;
      out_value_d  = '0;
      out_last_d   = 1'b1;
    end else if (cmd_i.ld_ram) begin
      out_valid_d  = 1'b1;
      out_status_d = cmd_i.ram_status;
      out_value_d  = rd_data;
      out_last_d   = (remain_q == RES_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cap_q       <= CAP_W'(CAP_RST);
      rd_idx_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      cap_q       <= cap_d;
      rd_idx_q    <= rd_idx_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

@@ rtl/circular_fifo_queue.sv @@
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tuser: command, tdata: item_value
// m_axis    out  tvalid/tready           tuser: status, tdata: item_value_res, tlast: last
// cfg       in   cfg_we_i (no wait)      cfg_wdata_i: capacity
//
// Push, rejected push, empty pop/dump: request taken and result loaded into the
// output register at the accepting edge. Pop: take, storage read, load. Dump:
// each entry is read through the single registered read port of the slot
// storage and then loaded; the next request is taken once the last entry is loaded.
// Reset empties the queue and sets capacity to min(DEPTH, 16); slot storage is
// not cleared. A stalled result holds in the output register and blocks work.
`default_nettype none

module circular_fifo_queue import cfq_pkg::*; #(
  parameter int DEPTH = CFQ_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [DATA_W-1:0] s_axis_tdata_i,   // [30:0] item_value, [31] zero
  input  wire logic [CMD_W-1:0]  s_axis_tuser_i,   // [1:0] command
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [DATA_W-1:0]      m_axis_tdata_o,   // [30:0] item_value_res, [31] zero
  output logic [STAT_W-1:0]      m_axis_tuser_o,   // [2:0] status
  output logic                   m_axis_tlast_o
);

  cfq_cmd_t         cmd;
  cfq_stat_t        stat;
  logic [VAL_W-1:0] out_value;

  cfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_cmd_i  (s_axis_tuser_i),
    .req_ready_o(s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_value_i(s_axis_tdata_i[VAL_W-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_status_o(m_axis_tuser_o),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(DATA_W - VAL_W){1'b0}}, out_value};

endmodule

`default_nettype wire

@@ rtl/cfq_checker.sv @@
`default_nettype none

module cfq_assertions import cfq_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic [CMD_W-1:0]  s_axis_tuser_i,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [DATA_W-1:0] m_axis_tdata_o,
  input wire logic [STAT_W-1:0] m_axis_tuser_o,
  input wire logic              m_axis_tlast_o
);

  // requests are only taken when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("request taken while result stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CMD_PUSH) |=>
      (m_axis_tvalid_o && m_axis_tlast_o
       && (m_axis_tuser_o == ST_PUSHED || m_axis_tuser_o == ST_FULL)))
    else $error("push gave no immediate result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_DUMP) |-> m_axis_tlast_o)
    else $error("single result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_PUSHED || m_axis_tuser_o == ST_FULL
                         || m_axis_tuser_o == ST_EMPTY)) |-> (m_axis_tdata_o == '0))
    else $error("data on a result without entry");

endmodule

bind circular_fifo_queue cfq_assertions u_cfq_assertions (.*);

`default_nettype wire
